FILE: src/pdl_pkg.sv
// Shared types, constants and arithmetic helpers for the PAL delay-line color converter.
`timescale 1ns / 1ps

package pdl_pkg;

   localparam int DATA_W    = 16;   // luma, chroma and coefficient width
   localparam int COL_W     = 10;   // column field width
   localparam int PIXEL_W   = 24;   // packed B,G,R result
   localparam int FRAC_BITS = 6;    // fraction bits of the channel values
   localparam int STORE_W   = 2 * DATA_W;  // one store entry holds V and U

   localparam int REQ_DATA_W = 64;  // 3*16 + 10 = 58, padded to whole bytes
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_FROM_U = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_FROM_V = 1'd1;

   localparam logic signed [DATA_W-1:0] GREEN_FROM_U_RESET = -16'sd6364;
   localparam logic signed [DATA_W-1:0] GREEN_FROM_V_RESET = -16'sd16692;

   typedef enum logic {
      STORE_CLEAR,
      STORE_RUN
   } store_state_type;

   // Doubling high multiply: floor(2*p / 65536) = p >>> 15, saturated to 16 bits.
   // Only -32768 * -32768 reaches +32768.
   function automatic logic signed [DATA_W-1:0] qdmulh_sat(input logic signed [2*DATA_W-1:0] p);
      logic signed [DATA_W:0] hi;
      hi = p[2*DATA_W-1:DATA_W-1];
      if (!hi[DATA_W] && hi[DATA_W-1]) begin
         return 16'sh7fff;
      end
      return hi[DATA_W-1:0];
   endfunction

   // Drop the fraction and clamp to 0..255.
   function automatic logic [7:0] to_u8(input logic signed [DATA_W-1:0] x);
      if (x[DATA_W-1]) begin
         return 8'd0;
      end
      if (x[DATA_W-2]) begin
         return 8'hff;
      end
      return x[FRAC_BITS+7:FRAC_BITS];
   endfunction

endpackage

FILE: src/pdl_line_store.sv
// Previous-line chroma store: single-port read-first memory with a clearing pass after reset.
`timescale 1ns / 1ps

module pdl_line_store #(
   parameter int LINE_LEN = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                acc_en,
   input  logic [$clog2(LINE_LEN)-1:0]         acc_addr,
   input  logic [pdl_pkg::STORE_W-1:0]         acc_wdata,
   output logic [pdl_pkg::STORE_W-1:0]         rd_data,
   output logic                                busy
);

   localparam int AW = $clog2(LINE_LEN);
   localparam logic [AW-1:0] LAST_ADDR = AW'(LINE_LEN - 1);

   pdl_pkg::store_state_type state_ff, state_in;
   logic [AW-1:0]               clr_addr_ff, clr_addr_in;
   logic [pdl_pkg::STORE_W-1:0] rd_data_ff;
   logic [pdl_pkg::STORE_W-1:0] store_mem [LINE_LEN];

   logic                        mem_we;
   logic [AW-1:0]               mem_addr;
   logic [pdl_pkg::STORE_W-1:0] mem_wdata;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pdl_pkg::STORE_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = pdl_pkg::STORE_RUN;
            end
         end
         pdl_pkg::STORE_RUN: begin
            state_in = pdl_pkg::STORE_RUN;
         end
         default: begin
            state_in = pdl_pkg::STORE_CLEAR;
         end
      endcase
   end

   // outputs: the clearing pass owns the port until it is done
   always_comb begin
      busy        = 1'b0;
      mem_we      = acc_en;
      mem_addr    = acc_addr;
      mem_wdata   = acc_wdata;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         pdl_pkg::STORE_CLEAR: begin
            busy        = 1'b1;
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         pdl_pkg::STORE_RUN: begin
            busy = 1'b0;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pdl_pkg::STORE_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // read-first: an access returns the old entry and stores the new one
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (acc_en) begin
         rd_data_ff <= store_mem[acc_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pal_delay_line_yuv_to_rgb.sv
// PAL delay-line chroma averaging and YUV to RGB conversion, one pixel per beat.
// Beats pass stages 1 to 4 and the output register; rsp stalls hold them there.
// Throughput: one beat per clock unless rsp stalls. The line store does a pixel's
//   read and write-back in one single-port access: pixels never wait on each other.
// Reset: coefficients return to their defaults; the line store is then zeroed entry
//   by entry, during which req_tready stays low (csr writes are still taken).
`timescale 1ns / 1ps

module pal_delay_line_yuv_to_rgb #(
   parameter int LINE_LEN = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] luma, [31:16] chroma_u, [47:32] chroma_v, [57:48] column, [63:58] zero
   input  logic [pdl_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [23:0] pixel_bgr
   output logic [pdl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [pdl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pdl_pkg::DATA_W-1:0]         csr_wdata
);

   localparam int DW    = pdl_pkg::DATA_W;
   localparam int CW    = pdl_pkg::COL_W;
   localparam int AW    = $clog2(LINE_LEN);
   // column % LINE_LEN by reciprocal: q = (col * ceil(2^22 / L)) >> 22 is exact
   // for every 10-bit column and every L up to 4096
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + LINE_LEN - 1) / LINE_LEN;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int QW          = (LINE_LEN >= (1 << CW)) ? 1 :
                                $clog2((1 << CW) / LINE_LEN + 1);
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

   // ---------------------------------------------------------------- csr
   logic signed [DW-1:0] coeff_u_ff, coeff_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_u_ff <= pdl_pkg::GREEN_FROM_U_RESET;
         coeff_v_ff <= pdl_pkg::GREEN_FROM_V_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pdl_pkg::CSR_GREEN_FROM_U: coeff_u_ff <= csr_wdata;
            pdl_pkg::CSR_GREEN_FROM_V: coeff_v_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // Each stage advances when it is empty or the stage after it advances, so a
   // stalled result only blocks what actually queues up behind it.
   logic v1_ff, v2_ff, v3_ff, v4_ff, out_valid_ff;
   logic ready1, ready2, ready3, ready4, ready_out;
   logic store_busy;
   logic req_accept;

   assign ready_out  = !out_valid_ff || rsp_tready;
   assign ready4     = !v4_ff || ready_out;
   assign ready3     = !v3_ff || ready4;
   assign ready2     = !v2_ff || ready3;
   assign ready1     = !v1_ff || ready2;
   assign req_tready = ready1 && !store_busy;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ready1)    v1_ff        <= req_accept;
         if (ready2)    v2_ff        <= v1_ff;
         if (ready3)    v3_ff        <= v2_ff;
         if (ready4)    v4_ff        <= v3_ff;
         if (ready_out) out_valid_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Unpack the beat and compute the line wrap count of the column.
   logic [CW-1:0]             req_col;
   logic [CW+RECIP_W-1:0]     quo_prod;
   logic signed [DW-1:0]      y1_ff, u1_ff, v1c_ff;
   logic [CW-1:0]             col1_ff;
   logic [QW-1:0]             quo1_ff;

   assign req_col  = req_tdata[3*DW+CW-1:3*DW];
   assign quo_prod = {{RECIP_W{1'b0}}, req_col} * {{CW{1'b0}}, RECIP_K};

   always_ff @(posedge clock) begin
      if (ready1) begin
         y1_ff   <= req_tdata[DW-1:0];
         u1_ff   <= req_tdata[2*DW-1:DW];
         v1c_ff  <= req_tdata[3*DW-1:2*DW];
         col1_ff <= req_col;
         quo1_ff <= QW'(quo_prod >> RECIP_SHIFT);
      end
   end

   // ---------------------------------------------------------------- stage 2
   // Fold the column into the store and hand the address to the store.
   logic [CW-1:0]             col_rem;
   logic signed [DW-1:0]      y2_ff, u2_ff, v2c_ff;
   logic [AW-1:0]             addr2_ff;

   assign col_rem = col1_ff - CW'(int'(quo1_ff) * LINE_LEN);

   always_ff @(posedge clock) begin
      if (ready2) begin
         y2_ff    <= y1_ff;
         u2_ff    <= u1_ff;
         v2c_ff   <= v1c_ff;
         addr2_ff <= AW'(col_rem);
      end
   end

   // ---------------------------------------------------------------- line store
   // The access fires as the pixel moves into stage 3: it reads the previous
   // line's chroma and writes this line's in the same cycle. A later pixel at the
   // same column accesses at a later edge, so it always sees the new value.
   logic                         store_en;
   logic [pdl_pkg::STORE_W-1:0]  store_rd;

   assign store_en = v2_ff && ready3;

   pdl_line_store #(
      .LINE_LEN (LINE_LEN)
   ) u_line_store (
      .clock     (clock),
      .reset     (reset),
      .acc_en    (store_en),
      .acc_addr  (addr2_ff),
      .acc_wdata ({v2c_ff, u2_ff}),
      .rd_data   (store_rd),
      .busy      (store_busy)
   );

   // ---------------------------------------------------------------- stage 3
   // Sum current and previous line chroma, wrapping at 16 bits.
   logic signed [DW-1:0] y3_ff, u3_ff, v3c_ff;
   logic signed [DW-1:0] y4_ff, usum4_ff, vsum4_ff;

   always_ff @(posedge clock) begin
      if (ready3) begin
         y3_ff  <= y2_ff;
         u3_ff  <= u2_ff;
         v3c_ff <= v2c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) begin
         y4_ff    <= y3_ff;
         usum4_ff <= u3_ff + store_rd[DW-1:0];
         vsum4_ff <= v3c_ff + store_rd[2*DW-1:DW];
      end
   end

   // ---------------------------------------------------------------- stage 4
   // Green chroma products; blue and red need only the sums.
   logic signed [2*DW-1:0] prod_u, prod_v;
   logic signed [2*DW-1:0] prod_u5_ff, prod_v5_ff;
   logic signed [DW-1:0]   y5_ff, blue5_ff, red5_ff;

   assign prod_u = usum4_ff * coeff_u_ff;
   assign prod_v = vsum4_ff * coeff_v_ff;

   always_ff @(posedge clock) begin
      if (ready_out) begin
         prod_u5_ff <= prod_u;
         prod_v5_ff <= prod_v;
         y5_ff      <= y4_ff;
         blue5_ff   <= y4_ff + usum4_ff;
         red5_ff    <= y4_ff + vsum4_ff;
      end
   end

   // ---------------------------------------------------------------- output
   // The product registers travel with out_valid_ff; the final add and clamp sit
   // in front of the port, so the held beat stays stable while rsp stalls.
   logic signed [DW-1:0] green;

   assign green = y5_ff + pdl_pkg::qdmulh_sat(prod_u5_ff) + pdl_pkg::qdmulh_sat(prod_v5_ff);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {pdl_pkg::to_u8(red5_ff), pdl_pkg::to_u8(green),
                        pdl_pkg::to_u8(blue5_ff)};

`ifndef SYNTHESIS
   // no pixel may enter while the store is still being cleared
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !req_tready)
      else $error("req beat accepted during line store clearing");

   // the store is only touched by a pixel that is moving into stage 3
   a_store_access_owned: assert property (@(posedge clock) disable iff (reset)
      store_en |=> v3_ff)
      else $error("line store access without a pixel in stage 3");

   // an accepted beat always lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> v1_ff)
      else $error("accepted req beat lost at stage 1");

   // stage 3 keeps its pixel while stage 4 cannot take it
   a_stage3_holds: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !ready4 |=> v3_ff && $stable(y3_ff))
      else $error("stage 3 pixel dropped during stall");
`endif

endmodule
